FILE: rtl/core/ipt_pkg.sv
`timescale 1ns / 1ps

package ipt_pkg;

  // Table geometry
  localparam int FRAMES    = 8;
  localparam int PID_BITS  = 16;
  localparam int PAGE_BITS = 20;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Fixed field widths of the request and result
  localparam int PID_FIELD_W   = 16;
  localparam int PAGE_FIELD_W  = 20;
  localparam int FRAME_FIELD_W = 3;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_INSERT    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAULT  = 2'd1,
    ST_MAPPED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    action_e                   action;
    logic [PID_FIELD_W-1:0]    process_id;
    logic [PAGE_FIELD_W-1:0]   page_number;
  } req_t;

  typedef struct packed {
    logic [FRAME_FIELD_W-1:0]  frame_index;
    status_e                   status;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic exec;      // search, commit the table write, load the result register
  } cmd_t;

endpackage

FILE: rtl/core/ipt_datapath.sv
`timescale 1ns / 1ps

module ipt_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipt_pkg::cmd_t cmd_i,
  input  ipt_pkg::req_t req_i,
  output ipt_pkg::rsp_t rsp_o
);

  ipt_pkg::req_t                      req_q;
  ipt_pkg::rsp_t                      rsp_q, rsp_d;
  logic [ipt_pkg::FRAMES-1:0]         valid_q, valid_d;
  logic [ipt_pkg::PID_BITS-1:0]       proc_q [ipt_pkg::FRAMES];
  logic [ipt_pkg::PAGE_BITS-1:0]      page_q [ipt_pkg::FRAMES];

  logic [ipt_pkg::PID_BITS-1:0]       pid;
  logic [ipt_pkg::PAGE_BITS-1:0]      page;
  logic [ipt_pkg::FRAMES-1:0]         match_vec;
  logic                               hit, free_found, do_write;
  logic [ipt_pkg::IDX_W-1:0]          hit_idx, free_idx;

  assign pid  = ipt_pkg::PID_BITS'(req_q.process_id);
  assign page = ipt_pkg::PAGE_BITS'(req_q.page_number);

  // Parallel tag compare against every frame
  always_comb begin
    for (int i = 0; i < ipt_pkg::FRAMES; i++) begin
      match_vec[i] = valid_q[i] && (proc_q[i] == pid) && (page_q[i] == page);
    end
  end

  // Lowest matching frame and lowest free frame
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = ipt_pkg::FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit     = 1'b1;
        hit_idx = ipt_pkg::IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = ipt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp_d.frame_index = '0;
    rsp_d.status      = ipt_pkg::ST_OK;
    do_write          = 1'b0;
    if (req_q.action == ipt_pkg::ACT_TRANSLATE) begin
      if (hit) begin
        rsp_d.frame_index = ipt_pkg::FRAME_FIELD_W'(hit_idx);
      end else begin
        rsp_d.status = ipt_pkg::ST_FAULT;
      end
    end else if (hit) begin
      rsp_d.status = ipt_pkg::ST_MAPPED;
    end else if (!free_found) begin
      rsp_d.status = ipt_pkg::ST_FULL;
    end else begin
      rsp_d.frame_index = ipt_pkg::FRAME_FIELD_W'(free_idx);
      do_write          = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.exec && do_write) begin
      valid_d[free_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
    if (cmd_i.exec && do_write) begin
      proc_q[free_idx] <= pid;
      page_q[free_idx] <= page;
    end
  end

  assign rsp_o = rsp_q;

  // Frames are never released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("ipt_datapath: occupied frame count dropped");

  // An allocating insert marks its frame occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_write |=> valid_q[$past(free_idx)])
    else $error("ipt_datapath: allocated frame not marked valid");

  // A hit never reports a frame that is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> valid_q[hit_idx])
    else $error("ipt_datapath: hit on a free frame");

endmodule

FILE: rtl/core/ipt_ctrl.sv
`timescale 1ns / 1ps

module ipt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ipt_pkg::cmd_t  cmd_o
);

  ipt_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ipt_pkg::S_EXEC;
        end
      end
      ipt_pkg::S_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ipt_pkg::S_IDLE;
        end
      end
      default: state_d = ipt_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      ipt_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ipt_pkg::S_EXEC: begin
        // hold the request until the result register can take it
        cmd_o.exec = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("ipt_ctrl: executed request left no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || !out_stall_i))
    else $error("ipt_ctrl: result register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> (state_q == ipt_pkg::S_EXEC))
    else $error("ipt_ctrl: accepted request not executed");

endmodule

FILE: rtl/core/inverted_page_table_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// request  | in        | in_valid_i / in_stall_o    | in_data_i  (ipt_pkg::req_t)
// result   | out       | out_valid_o / out_stall_i  | out_data_o (ipt_pkg::rsp_t)
//
// Each request is captured in the idle state; the execute state then searches
// all frames in parallel, commits an insert and loads the result register.
// A new request is taken while the previous result still waits downstream.
// A stalled result holds the request in the execute state until it drains.
// Reset marks every frame free; process and page tags are not cleared.

module inverted_page_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ipt_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ipt_pkg::rsp_t out_data_o
);

  ipt_pkg::cmd_t cmd;

  ipt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ipt_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

endmodule
